// File: design/ame_pkg.sv
// ----------------------------------------------------------------------------
// ame_pkg
// Shared types, constants and helpers of the accumulator machine executor.
// ----------------------------------------------------------------------------
package ame_pkg;

   localparam int MEM_WORDS  = 10;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(MEM_WORDS);
   // wide enough for any 4-bit operand and for the dump step counter
   localparam int IDX_W      = $clog2(MEM_WORDS + 16);
   localparam int PC_W       = 16;
   localparam logic [PC_W-1:0] PC_RESET = PC_W'(10);

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef enum logic [3:0] {
      OP_LDR   = 4'd0,
      OP_STR   = 4'd1,
      OP_INC   = 4'd2,
      OP_DEC   = 4'd3,
      OP_ADD   = 4'd4,
      OP_SET   = 4'd5,
      OP_SHW   = 4'd6,
      OP_PAUSE = 4'd7,
      OP_END   = 4'd8,
      OP_NOP   = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      SHOW_MEM = 3'd0,
      SHOW_ACC = 3'd1,
      SHOW_MAR = 3'd2,
      SHOW_MDR = 3'd3,
      SHOW_ICR = 3'd4,
      SHOW_UC  = 3'd5
   } show_type;

   typedef enum logic [1:0] {
      KIND_MEM  = 2'd0,
      KIND_MAR  = 2'd1,
      KIND_ACC  = 2'd2,
      KIND_VIEW = 2'd3
   } kind_type;

   // decoded request as it travels from front to back
   typedef struct packed {
      op_type             op;
      logic [3:0]         opcode;
      logic [3:0]         operand_a;
      logic [IDX_W-1:0]   rd_a;
      logic [IDX_W-1:0]   rd_b;
      logic [IDX_W-1:0]   wr_addr;
      logic               has_b;
      logic               has_c;
      logic signed [31:0] immediate;
      logic [2:0]         show_target;
   } cmd_type;

   typedef struct packed {
      kind_type           kind;
      logic [3:0]         word_index;
      logic signed [31:0] value;
      logic [3:0]         instr_opcode;
      logic [3:0]         instr_operand;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic halted;
      logic busy;
   } back_status_type;

   // data word to result value: sign-extend or truncate to 32 bits
   function automatic logic signed [31:0] to_value(data_type d);
      return 32'(d);
   endfunction

endpackage

// File: design/ame_front.sv
// ----------------------------------------------------------------------------
// ame_front
// Accepts requests, decodes them and holds them in a short command queue.
// ----------------------------------------------------------------------------
module ame_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [3:0]          req_opcode,
   input  logic [3:0]          req_operand_a,
   input  logic [3:0]          req_operand_b,
   input  logic [3:0]          req_operand_c,
   input  logic                req_has_b,
   input  logic                req_has_c,
   input  logic signed [31:0]  req_immediate,
   input  logic [2:0]          req_show_target,
   output logic                cmd_valid,
   input  logic                cmd_pop,
   output ame_pkg::cmd_type    cmd
);
   import ame_pkg::*;

   cmd_type               dec;
   op_type                op_class;
   cmd_type               q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  push_ok;
   logic                  pop_ok;

   // unknown opcodes behave as the no-op
   always_comb begin
      if (req_opcode > 4'(OP_NOP)) begin
         op_class = OP_NOP;
      end else begin
         op_class = op_type'(req_opcode);
      end
   end

   always_comb begin
      dec.op          = op_class;
      dec.opcode      = req_opcode;
      dec.operand_a   = req_operand_a;
      dec.rd_a        = (op_class == OP_PAUSE) ? '0 : IDX_W'(req_operand_a);
      dec.rd_b        = IDX_W'(req_operand_b);
      dec.wr_addr     = (op_class == OP_ADD) ? IDX_W'(req_operand_c)
                                             : IDX_W'(req_operand_a);
      dec.has_b       = req_has_b;
      dec.has_c       = req_has_c;
      dec.immediate   = req_immediate;
      dec.show_target = req_show_target;
   end

   assign full      = (cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: design/ame_back.sv
// ----------------------------------------------------------------------------
// ame_back
// Executes decoded requests against data memory, accumulator and counter.
// ----------------------------------------------------------------------------
module ame_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_pop,
   input  ame_pkg::cmd_type         cmd,
   output logic                     rsp_push,
   output ame_pkg::rsp_type         rsp_in,
   input  logic                     rsp_full,
   output ame_pkg::back_status_type status
);
   import ame_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUMP
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   data_type         acc_ff, acc_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [PC_W-1:0]  mar_ff, mar_in;
   logic             halted_ff, halted_in;
   logic [IDX_W-1:0] step_ff, step_in;

   // data memory, two registered read ports and one write port
   data_type         mem [MEM_WORDS];
   logic             vld_ff [MEM_WORDS];
   data_type         rd0_ff, rd1_ff;
   logic             rd0_en, rd1_en;
   logic [IDX_W-1:0] rd0_addr, rd1_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   data_type         wr_data;
   logic             wr_ok;

   data_type         sum;
   logic             want;
   rsp_type          rsp;
   logic [2:0]       view_sel;

   assign sum      = acc_ff + rd0_ff + (cmd_ff.has_b ? rd1_ff : '0);
   assign view_sel = 3'(step_ff - IDX_W'(MEM_WORDS));

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      mar_in    = mar_ff;
      halted_in = halted_ff;
      step_in   = step_ff;
      cmd_pop   = 1'b0;
      rd0_en    = 1'b0;
      rd1_en    = 1'b0;
      rd0_addr  = cmd.rd_a;
      rd1_addr  = cmd.rd_b;
      wr_en     = 1'b0;
      wr_addr   = cmd_ff.wr_addr;
      wr_data   = acc_ff;
      want      = 1'b0;
      rsp       = '0;
      rsp.kind  = KIND_MEM;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (!halted_ff) begin
                  rd0_en   = 1'b1;
                  rd1_en   = 1'b1;
                  cmd_in   = cmd;
                  mar_in   = pc_ff;
                  pc_in    = pc_ff + 1'b1;
                  step_in  = '0;
                  state_in = (cmd.op == OP_PAUSE) ? ST_DUMP : ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            unique case (cmd_ff.op)
               OP_LDR: acc_in = rd0_ff;
               OP_STR: wr_en = 1'b1;
               OP_INC: begin
                  wr_en   = 1'b1;
                  wr_data = acc_ff + DATA_WIDTH'(1);
               end
               OP_DEC: begin
                  wr_en   = 1'b1;
                  wr_data = acc_ff - DATA_WIDTH'(1);
               end
               OP_ADD: begin
                  if (cmd_ff.has_b || !cmd_ff.has_c) begin
                     acc_in = sum;
                  end
                  if (cmd_ff.has_b && cmd_ff.has_c) begin
                     wr_en   = 1'b1;
                     wr_data = sum;
                  end
               end
               OP_SET: begin
                  wr_en   = 1'b1;
                  wr_data = DATA_WIDTH'(cmd_ff.immediate);
               end
               OP_SHW: begin
                  rsp.last = 1'b1;
                  unique case (show_type'(cmd_ff.show_target))
                     SHOW_MEM: begin
                        want           = 1'b1;
                        rsp.kind       = KIND_MEM;
                        rsp.word_index = cmd_ff.operand_a;
                        rsp.value      = to_value(rd0_ff);
                     end
                     SHOW_ACC: begin
                        want      = 1'b1;
                        rsp.kind  = KIND_ACC;
                        rsp.value = to_value(acc_ff);
                     end
                     SHOW_MAR: begin
                        want      = 1'b1;
                        rsp.kind  = KIND_MAR;
                        rsp.value = 32'(mar_ff);
                     end
                     SHOW_MDR, SHOW_ICR, SHOW_UC: begin
                        want              = 1'b1;
                        rsp.kind          = KIND_VIEW;
                        rsp.instr_opcode  = cmd_ff.opcode;
                        rsp.instr_operand = cmd_ff.operand_a;
                     end
                     default: want = 1'b0;
                  endcase
               end
               OP_END: halted_in = 1'b1;
               default: ;
            endcase
            if (!(want && rsp_full)) begin
               state_in = ST_IDLE;
            end
         end

         ST_DUMP: begin
            want = 1'b1;
            if (step_ff < IDX_W'(MEM_WORDS)) begin
               rsp.kind       = KIND_MEM;
               rsp.word_index = 4'(step_ff);
               rsp.value      = to_value(rd0_ff);
            end else begin
               case (view_sel)
                  3'd0: begin
                     rsp.kind  = KIND_MAR;
                     rsp.value = 32'(mar_ff);
                  end
                  3'd2: begin
                     rsp.kind  = KIND_ACC;
                     rsp.value = to_value(acc_ff);
                  end
                  default: begin
                     rsp.kind          = KIND_VIEW;
                     rsp.instr_opcode  = cmd_ff.opcode;
                     rsp.instr_operand = cmd_ff.operand_a;
                  end
               endcase
               rsp.last = (view_sel == 3'd4);
            end
            if (!rsp_full) begin
               step_in  = step_ff + 1'b1;
               rd0_en   = 1'b1;
               rd0_addr = step_ff + 1'b1;
               if (rsp.last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // a stalled result blocks the write; only SHW and the PAUSE dump ever stall
      if (want && rsp_full) begin
         wr_en = 1'b0;
      end
   end

   assign rsp_push      = want && !rsp_full;
   assign rsp_in        = rsp;
   assign status.halted = halted_ff;
   assign status.busy   = (state_ff != ST_IDLE);
   assign wr_ok         = wr_en && (wr_addr < IDX_W'(MEM_WORDS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         acc_ff    <= '0;
         pc_ff     <= PC_RESET;
         halted_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         acc_ff    <= acc_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         step_ff   <= step_in;
      end
      cmd_ff <= cmd_in;
      mar_ff <= mar_in;
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr[ADDR_W-1:0]] <= wr_data;
      end
   end

   // entries read as zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_WORDS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (wr_ok) begin
         vld_ff[wr_addr[ADDR_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd0_en) begin
         rd0_ff <= (rd0_addr < IDX_W'(MEM_WORDS) && vld_ff[rd0_addr[ADDR_W-1:0]])
                   ? mem[rd0_addr[ADDR_W-1:0]] : '0;
      end
      if (rd1_en) begin
         rd1_ff <= (rd1_addr < IDX_W'(MEM_WORDS) && vld_ff[rd1_addr[ADDR_W-1:0]])
                   ? mem[rd1_addr[ADDR_W-1:0]] : '0;
      end
   end

endmodule

// File: design/ame_rsp_queue.sv
// ----------------------------------------------------------------------------
// ame_rsp_queue
// Result queue between the executor and the result port.
// ----------------------------------------------------------------------------
module ame_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_push,
   input  ame_pkg::rsp_type rsp_in,
   output logic             rsp_full,
   input  logic             pop,
   output logic             empty,
   output ame_pkg::rsp_type rsp_out
);
   import ame_pkg::*;

   rsp_type               q_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  push_ok;
   logic                  pop_ok;

   assign rsp_full = (cnt_ff == RSPQ_CNT_W'(RSPQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign rsp_out  = q_ff[rd_ptr_ff];
   assign push_ok  = rsp_push && !rsp_full;
   assign pop_ok   = pop && !empty;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: design/accumulator_machine_executor.sv
// ----------------------------------------------------------------------------
// accumulator_machine_executor
// Runs one decoded accumulator-machine instruction per request.
// ----------------------------------------------------------------------------
//
//   channel   | handshake         | payload
//   ----------+-------------------+------------------------------------------
//   request   | push / full       | req_opcode .. req_show_target
//   result    | empty / pop       | rsp_kind .. rsp_last
//
// The executor reads a request's operand words from data memory as it takes
// it, then executes and writes back; SHW waits there while results stall.
// PAUSE streams fifteen dump-counter results, one a cycle unless stalled.
// A two-entry command queue in front and a four-entry result queue behind
// let either port stall without blocking the other until a queue fills.
// Synchronous reset clears accumulator, memory valid bits and halt; the
// program counter restarts at ten. After END, requests are taken and dropped.
//
module accumulator_machine_executor (
   input  logic               clock,
   input  logic               reset,
   // request side
   input  logic               push,
   output logic               full,
   input  logic [3:0]         req_opcode,
   input  logic [3:0]         req_operand_a,
   input  logic [3:0]         req_operand_b,
   input  logic [3:0]         req_operand_c,
   input  logic               req_has_b,
   input  logic               req_has_c,
   input  logic signed [31:0] req_immediate,
   input  logic [2:0]         req_show_target,
   // result side
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_kind,
   output logic [3:0]         rsp_word_index,
   output logic signed [31:0] rsp_value,
   output logic [3:0]         rsp_instr_opcode,
   output logic [3:0]         rsp_instr_operand,
   output logic               rsp_last
);
   import ame_pkg::*;

   logic            cmd_valid;
   logic            cmd_pop;
   cmd_type         cmd;
   logic            rsp_push;
   logic            rsp_full;
   rsp_type         rsp_in;
   rsp_type         rsp_out;
   back_status_type status;

   // front: decode and queue requests
   ame_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_opcode      (req_opcode),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .req_operand_c   (req_operand_c),
      .req_has_b       (req_has_b),
      .req_has_c       (req_has_c),
      .req_immediate   (req_immediate),
      .req_show_target (req_show_target),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd             (cmd)
   );

   // back: memory, accumulator, program counter, result generation
   ame_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_push  (rsp_push),
      .rsp_in    (rsp_in),
      .rsp_full  (rsp_full),
      .status    (status)
   );

   // results wait here until popped
   ame_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp_in),
      .rsp_full (rsp_full),
      .pop      (pop),
      .empty    (empty),
      .rsp_out  (rsp_out)
   );

   assign rsp_kind          = rsp_out.kind;
   assign rsp_word_index    = rsp_out.word_index;
   assign rsp_value         = rsp_out.value;
   assign rsp_instr_opcode  = rsp_out.instr_opcode;
   assign rsp_instr_operand = rsp_out.instr_operand;
   assign rsp_last          = rsp_out.last;

   // the executor never pushes into a full result queue
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   // once halted, no further results are produced
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      status.halted |-> !rsp_push)
      else $error("result produced after END");

   // results only come from an instruction in flight
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      !status.busy |-> !rsp_push)
      else $error("result produced while executor idle");

   // the executor takes commands only from a non-empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

endmodule

// File: tb/tb_accumulator_machine_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accumulator_machine_executor
// Drives decoded instructions into the executor and checks every result
// against a behavioral copy of the machine kept alongside the run: data
// memory, accumulator, program counter and halt flag. Directed cases first,
// then random programs with bursty idling on both queues, a long result
// stall that backs up the request side, and a final halt.
// ----------------------------------------------------------------------------
module tb_accumulator_machine_executor;
   import ame_pkg::*;

   // cycles with no handshake on either side before the run is declared hung
   localparam int QUIET_LIMIT   = 2000;
   // length of the deliberate result-side stall
   localparam int HOLD_CYCLES   = 300;
   // drain margin for requests that produce no result but are still in flight
   localparam int SETTLE_CYCLES = 40;

   // opcode and show target codes outside the defined set
   localparam logic [3:0] OP_UNDEF       = 4'd15;
   localparam logic [2:0] SHOW_UNUSED_LO = 3'd6;
   localparam logic [2:0] SHOW_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [3:0]         operand_a;
      logic [3:0]         operand_b;
      logic [3:0]         operand_c;
      logic               has_b;
      logic               has_c;
      logic signed [31:0] immediate;
      logic [2:0]         show_target;
   } instr_type;

   typedef struct packed {
      kind_type           kind;
      logic [3:0]         word_index;
      logic signed [31:0] value;
      logic [3:0]         instr_opcode;
      logic [3:0]         instr_operand;
      logic               last;
   } view_type;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               push              = 1'b0;
   logic [3:0]         req_opcode        = '0;
   logic [3:0]         req_operand_a     = '0;
   logic [3:0]         req_operand_b     = '0;
   logic [3:0]         req_operand_c     = '0;
   logic               req_has_b         = 1'b0;
   logic               req_has_c         = 1'b0;
   logic signed [31:0] req_immediate     = '0;
   logic [2:0]         req_show_target   = '0;
   logic               pop               = 1'b0;
   logic               full;
   logic               empty;
   logic [1:0]         rsp_kind;
   logic [3:0]         rsp_word_index;
   logic signed [31:0] rsp_value;
   logic [3:0]         rsp_instr_opcode;
   logic [3:0]         rsp_instr_operand;
   logic               rsp_last;

   accumulator_machine_executor uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_opcode        (req_opcode),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_operand_c     (req_operand_c),
      .req_has_b         (req_has_b),
      .req_has_c         (req_has_c),
      .req_immediate     (req_immediate),
      .req_show_target   (req_show_target),
      .empty             (empty),
      .pop               (pop),
      .rsp_kind          (rsp_kind),
      .rsp_word_index    (rsp_word_index),
      .rsp_value         (rsp_value),
      .rsp_instr_opcode  (rsp_instr_opcode),
      .rsp_instr_operand (rsp_instr_operand),
      .rsp_last          (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Machine image: what the executor should hold after every accepted
   // request. Reset values match the block: memory and accumulator zero,
   // program counter ten, running.
   // ------------------------------------------------------------------------
   data_type         mem_img [MEM_WORDS];
   data_type         acc_img     = '0;
   logic [PC_W-1:0]  pc_img      = PC_RESET;
   logic             halted_img  = 1'b0;

   // results the executor owes us, oldest first
   view_type         due_views [$];

   int               fail_count   = 0;
   int               quiet_cycles = 0;
   bit               send_idle    = 1'b0;
   bit               pop_idle     = 1'b0;
   bit               hold_req     = 1'b0;

   initial begin
      foreach (mem_img[i]) mem_img[i] = '0;
   end

   // out-of-range words read as zero and swallow writes
   function automatic data_type read_word(logic [3:0] idx);
      return (idx < MEM_WORDS) ? mem_img[idx] : '0;
   endfunction

   function automatic void write_word(logic [3:0] idx, data_type v);
      if (idx < MEM_WORDS) mem_img[idx] = v;
   endfunction

   function automatic void owe_view(kind_type k, logic [3:0] idx, data_type v,
                                    logic [3:0] iop, logic [3:0] iopa, logic lst);
      view_type r;
      r.kind          = k;
      r.word_index    = idx;
      r.value         = 32'(v);
      r.instr_opcode  = iop;
      r.instr_operand = iopa;
      r.last          = lst;
      due_views.insert(due_views.size(), r);
   endfunction

   // Executes one instruction on the image and queues the results it owes.
   function automatic void exec_instr(instr_type in);
      logic [PC_W-1:0] fetch_addr;
      data_type        mar_val;
      if (halted_img) return;              // everything after END is dropped
      fetch_addr = pc_img;
      pc_img     = pc_img + 1'b1;          // wraps at 16 bits
      mar_val    = data_type'(fetch_addr);
      case (in.opcode)
         OP_LDR: acc_img = read_word(in.operand_a);
         OP_STR: write_word(in.operand_a, acc_img);
         OP_INC: write_word(in.operand_a, acc_img + 1);
         OP_DEC: write_word(in.operand_a, acc_img - 1);
         OP_ADD: begin
            // destination without a second operand does nothing
            if (!in.has_b && !in.has_c) begin
               acc_img = acc_img + read_word(in.operand_a);
            end else if (in.has_b) begin
               acc_img = acc_img + read_word(in.operand_a) + read_word(in.operand_b);
               if (in.has_c) write_word(in.operand_c, acc_img);
            end
         end
         OP_SET: write_word(in.operand_a, in.immediate);
         OP_SHW: begin
            case (in.show_target)
               SHOW_MEM: owe_view(KIND_MEM, in.operand_a, read_word(in.operand_a),
                                  '0, '0, 1'b1);
               SHOW_ACC: owe_view(KIND_ACC, '0, acc_img, '0, '0, 1'b1);
               SHOW_MAR: owe_view(KIND_MAR, '0, mar_val, '0, '0, 1'b1);
               SHOW_MDR, SHOW_ICR, SHOW_UC:
                  owe_view(KIND_VIEW, '0, '0, in.opcode, in.operand_a, 1'b1);
               default: ;                  // unused targets show nothing
            endcase
         end
         OP_PAUSE: begin
            for (int i = 0; i < MEM_WORDS; i++)
               owe_view(KIND_MEM, 4'(i), mem_img[i], '0, '0, 1'b0);
            owe_view(KIND_MAR, '0, mar_val, '0, '0, 1'b0);
            owe_view(KIND_VIEW, '0, '0, in.opcode, in.operand_a, 1'b0);
            owe_view(KIND_ACC, '0, acc_img, '0, '0, 1'b0);
            owe_view(KIND_VIEW, '0, '0, in.opcode, in.operand_a, 1'b0);
            owe_view(KIND_VIEW, '0, '0, in.opcode, in.operand_a, 1'b1);
         end
         OP_END: halted_img = 1'b1;
         default: ;                        // NOP and undefined opcodes
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request side. push stays high from one request to the next; it only
   // drops for an idle burst or a drain, so it never gets two updates in
   // one step.
   // ------------------------------------------------------------------------
   task automatic push_instr(instr_type in);
      if (send_idle && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      push            <= 1'b1;
      req_opcode      <= in.opcode;
      req_operand_a   <= in.operand_a;
      req_operand_b   <= in.operand_b;
      req_operand_c   <= in.operand_c;
      req_has_b       <= in.has_b;
      req_has_c       <= in.has_c;
      req_immediate   <= in.immediate;
      req_show_target <= in.show_target;
      do @(posedge clock); while (full);
      exec_instr(in);
   endtask

   // sender goes quiet until every owed result is back, then lets
   // result-free requests still in the pipe finish
   task automatic wait_drained();
      push <= 1'b0;
      while (due_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic instr_type mk(logic [3:0] op, logic [3:0] a,
                                    logic [3:0] b = '0, logic [3:0] c = '0,
                                    logic hb = 1'b0, logic hc = 1'b0,
                                    logic signed [31:0] imm = '0,
                                    logic [2:0] tgt = SHOW_MEM);
      instr_type r;
      r.opcode      = op;
      r.operand_a   = a;
      r.operand_b   = b;
      r.operand_c   = c;
      r.has_b       = hb;
      r.has_c       = hc;
      r.immediate   = imm;
      r.show_target = tgt;
      return r;
   endfunction

   // mostly valid word indexes, some past the end of memory
   function automatic logic [3:0] rand_index();
      if ($urandom_range(0, 9) == 0) return 4'($urandom_range(10, 15));
      return 4'($urandom_range(0, MEM_WORDS - 1));
   endfunction

   // Random program step, never END. Heavy on SHW and PAUSE so results flow;
   // SET values lean toward the wrap points.
   function automatic instr_type rand_instr();
      instr_type  r;
      logic [3:0] op;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)       op = OP_PAUSE;
      else if (pick < 35) op = OP_SHW;
      else begin
         op = 4'($urandom_range(0, 15));
         if (op == OP_END) op = OP_NOP;
      end
      r = mk(op, rand_index(), rand_index(), rand_index(),
             1'($urandom), 1'($urandom), 32'($urandom), 3'($urandom_range(0, 7)));
      case ($urandom_range(0, 7))
         0: r.immediate = 32'h8000_0000;
         1: r.immediate = 32'h7FFF_FFFF;
         2: r.immediate = 32'hFFFF_FFFF;
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random pop bursts, plus a long hold on request.
   // ------------------------------------------------------------------------
   initial begin
      @(negedge reset);
      forever begin
         if (hold_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (pop_idle && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] exp_val,
                                       logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d (0x%08h), actual %0d (0x%08h)",
                name, exp_val, exp_val, act_val, act_val);
         fail_count++;
      end
   endfunction

   // every popped result is matched against the oldest owed one
   always @(posedge clock) begin
      view_type owed;
      if (!reset && pop && !empty) begin
         if (due_views.size() == 0) begin
            $error("unexpected result: kind %0d index %0d value %0d",
                   rsp_kind, rsp_word_index, rsp_value);
            fail_count++;
         end else begin
            owed = due_views.pop_front();
            check_field("rsp_kind", 32'(owed.kind), 32'(rsp_kind));
            check_field("rsp_word_index", 32'(owed.word_index), 32'(rsp_word_index));
            check_field("rsp_value", owed.value, rsp_value);
            check_field("rsp_instr_opcode", 32'(owed.instr_opcode),
                        32'(rsp_instr_opcode));
            check_field("rsp_instr_operand", 32'(owed.instr_operand),
                        32'(rsp_instr_operand));
            check_field("rsp_last", 32'(owed.last), 32'(rsp_last));
         end
      end
   end

   // hang detector: counts cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // dump straight out of reset: zero memory and accumulator, MAR at ten
   task automatic test_reset_state();
      push_instr(mk(OP_PAUSE, 4'd0));
   endtask

   // every opcode but END, each ADD form, wrap points, bad indexes, every show target
   task automatic test_each_op();
      push_instr(mk(OP_SET, 4'd0, .imm(32'h7FFF_FFFF)));
      push_instr(mk(OP_SET, 4'd9, .imm(32'h8000_0000)));
      push_instr(mk(OP_SET, 4'd15, .imm(32'h1234_5678)));   // dropped
      push_instr(mk(OP_LDR, 4'd0));
      push_instr(mk(OP_INC, 4'd1));                          // wraps to min
      push_instr(mk(OP_DEC, 4'd2));
      push_instr(mk(OP_LDR, 4'd9));
      push_instr(mk(OP_DEC, 4'd3));                          // wraps to max
      push_instr(mk(OP_STR, 4'd4));
      push_instr(mk(OP_ADD, 4'd0));
      push_instr(mk(OP_ADD, 4'd0, 4'd9, .hb(1'b1)));
      push_instr(mk(OP_ADD, 4'd1, 4'd2, 4'd5, 1'b1, 1'b1));
      push_instr(mk(OP_ADD, 4'd0, 4'd0, 4'd6, 1'b0, 1'b1));  // no effect
      push_instr(mk(OP_LDR, 4'd12));                         // reads zero
      push_instr(mk(OP_STR, 4'd15));                         // dropped
      push_instr(mk(OP_NOP, 4'd3));
      push_instr(mk(OP_UNDEF, 4'd7));
      push_instr(mk(OP_SHW, 4'd15, .tgt(SHOW_MEM)));
      push_instr(mk(OP_SHW, 4'd5, .tgt(SHOW_MEM)));
      push_instr(mk(OP_SHW, 4'd0, .tgt(SHOW_ACC)));
      push_instr(mk(OP_SHW, 4'd0, .tgt(SHOW_MAR)));
      push_instr(mk(OP_SHW, 4'd8, .tgt(SHOW_MDR)));
      push_instr(mk(OP_SHW, 4'd9, .tgt(SHOW_ICR)));
      push_instr(mk(OP_SHW, 4'd1, .tgt(SHOW_UC)));
      push_instr(mk(OP_SHW, 4'd2, .tgt(SHOW_UNUSED_LO)));
      push_instr(mk(OP_SHW, 4'd3, .tgt(SHOW_UNUSED_HI)));
      push_instr(mk(OP_PAUSE, 4'd6));
   endtask

   task automatic test_random_program(int count);
      repeat (count) push_instr(rand_instr());
   endtask

   // results held back for a long stretch while requests keep coming, so
   // both queues fill and full must rise; then a full drain
   task automatic test_backpressure();
      bit saved_idle;
      saved_idle = send_idle;
      send_idle  = 1'b0;
      hold_req   = 1'b1;
      repeat (24) begin
         if ($urandom_range(0, 2) == 0) push_instr(mk(OP_PAUSE, rand_index()));
         else push_instr(rand_instr());
      end
      send_idle = saved_idle;
      wait_drained();
   endtask

   // END stops the machine for good; what follows is taken and dropped
   task automatic test_halt();
      push_instr(mk(OP_END, 4'd0));
      repeat (12) begin
         if ($urandom_range(0, 1) == 0) push_instr(mk(OP_PAUSE, rand_index()));
         else push_instr(rand_instr());
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset     <= 1'b0;
      send_idle  = 1'b1;
      pop_idle   = 1'b1;

      test_reset_state();
      test_each_op();
      wait_drained();
      test_random_program(200);
      test_backpressure();
      test_random_program(150);

      // closing stretch at full rate on both sides
      send_idle = 1'b0;
      pop_idle  = 1'b0;
      test_random_program(120);
      test_halt();

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
